[hdl/lpfr_pkg.sv]
// Shared types and constants for the length-prefixed frame receiver.
// No dependencies.
`default_nettype none

package lpfr_pkg;

  localparam int unsigned STORE_DEPTH_DEF = 64;
  localparam logic [7:0]  FLAG_RESET      = 8'd85;

  // Receive parser phase.
  typedef enum logic [1:0] {
    PH_HUNT,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_DATA
  } phase_t;

  // One result item as it leaves the drain side.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       empty;
  } out_item_t;

endpackage

`default_nettype wire

[hdl/lpfr_front.sv]
// Front side: flag hunt, length parse, payload store writes, frame commands.
// Depends on lpfr_pkg.
`default_nettype none

module lpfr_front #(
  parameter int unsigned STORE_DEPTH = 64,
  parameter int unsigned CNT_W       = $clog2(STORE_DEPTH + 1),
  parameter int unsigned ADDR_W      = $clog2(STORE_DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [7:0]        start_flag,
  input  wire logic              push,
  input  wire logic [7:0]        rx_byte,
  output logic                   full,
  input  wire logic              store_free,
  output logic                   wr_en,
  output logic [ADDR_W-1:0]      wr_addr,
  output logic [7:0]             wr_data,
  output logic                   cmd_push,
  output logic [CNT_W-1:0]       cmd_count
);
  import lpfr_pkg::*;

  phase_t            phase, phase_next;
  logic [15:0]       exp_len, exp_len_next;
  logic [CNT_W-1:0]  fill_count, fill_count_next;
  logic [CNT_W-1:0]  fill_inc;
  logic              accept;
  logic              is_flag;

  // Payload bytes need the store; hold them off while a frame drains.
  assign full     = (phase == PH_DATA) && !store_free;
  assign accept   = push && !full;
  assign is_flag  = (rx_byte == start_flag);
  assign fill_inc = fill_count + CNT_W'(1);
  assign wr_addr  = fill_count[ADDR_W-1:0];
  assign wr_data  = rx_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HUNT;
      exp_len    <= '0;
      fill_count <= '0;
    end else begin
      phase      <= phase_next;
      exp_len    <= exp_len_next;
      fill_count <= fill_count_next;
    end
  end

  always_comb begin
    phase_next      = phase;
    exp_len_next    = exp_len;
    fill_count_next = fill_count;
    wr_en           = 1'b0;
    cmd_push        = 1'b0;
    cmd_count       = fill_count;
    if (accept) begin
      unique case (phase)
        PH_HUNT: begin
          if (is_flag) phase_next = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          exp_len_next = {8'd0, rx_byte};
          phase_next   = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          exp_len_next = {exp_len[7:0], rx_byte};
          phase_next   = PH_DATA;
        end
        PH_DATA: begin
          priority if (is_flag) begin
            // flag ends the frame; emit only on an exact count
            cmd_push        = (16'(fill_count) == exp_len);
            fill_count_next = '0;
            phase_next      = PH_LEN_HI;
          end else if (fill_count == CNT_W'(STORE_DEPTH)) begin
            fill_count_next = '0;
            phase_next      = PH_HUNT;
          end else begin
            wr_en           = 1'b1;
            fill_count_next = fill_inc;
            if (16'(fill_inc) == exp_len) begin
              cmd_push        = 1'b1;
              cmd_count       = fill_inc;
              fill_count_next = '0;
              phase_next      = PH_HUNT;
            end
          end
        end
        default: phase_next = PH_HUNT;
      endcase
    end
  end

endmodule

`default_nettype wire

[hdl/lpfr_cmdq.sv]
// Two-entry queue of frame commands (byte count, zero for an empty frame).
// No package dependencies.
`default_nettype none

module lpfr_cmdq #(
  parameter int unsigned W = 7
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire logic [W-1:0] din,
  input  wire logic         pop,
  output logic [W-1:0]      dout,
  output logic              empty,
  output logic              full
);

  logic [W-1:0] ent [2];
  logic         wptr, rptr;
  logic [1:0]   cnt;
  logic         do_push, do_pop;

  assign empty   = (cnt == 2'd0);
  assign full    = (cnt == 2'd2);
  assign dout    = ent[rptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) ent[wptr] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (do_push) wptr <= ~wptr;
      if (do_pop)  rptr <= ~rptr;
      cnt <= cnt + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

`default_nettype wire

[hdl/lpfr_back.sv]
// Back side: payload store, drain sequencer and two-entry result queue.
// Depends on lpfr_pkg.
`default_nettype none

module lpfr_back #(
  parameter int unsigned STORE_DEPTH = 64,
  parameter int unsigned CNT_W       = $clog2(STORE_DEPTH + 1),
  parameter int unsigned ADDR_W      = $clog2(STORE_DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [7:0]        wr_data,
  input  wire logic              cmd_empty,
  input  wire logic [CNT_W-1:0]  cmd_count,
  output logic                   cmd_pop,
  output logic                   busy,
  output lpfr_pkg::out_item_t    out_item,
  output logic                   out_empty,
  input  wire logic              out_pop
);
  import lpfr_pkg::*;

  logic [7:0]       mem [STORE_DEPTH];
  logic [7:0]       rd_data;
  logic             rd_valid, rd_last, rd_empty;

  logic             active;
  logic [CNT_W-1:0] cur_idx, total;
  logic [CNT_W-1:0] cur_inc;
  logic             room, issue, issue_last;

  out_item_t        oq [2];
  logic             owptr, orptr;
  logic [1:0]       ocnt;
  logic             o_pop;

  assign busy       = active;
  assign cmd_pop    = !active && !cmd_empty;
  assign cur_inc    = cur_idx + CNT_W'(1);
  // count in-flight read so the queue never overflows
  assign room       = (ocnt == 2'd0) || ((ocnt == 2'd1) && !rd_valid);
  assign issue      = active && room;
  assign issue_last = (total == '0) || (cur_inc == total);

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (issue) rd_data <= mem[cur_idx[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_last  <= issue_last;
      rd_empty <= (total == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      cur_idx  <= '0;
      total    <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= issue;
      if (cmd_pop) begin
        active  <= 1'b1;
        cur_idx <= '0;
        total   <= cmd_count;
      end else if (issue) begin
        if (issue_last) active <= 1'b0;
        else            cur_idx <= cur_inc;
      end
    end
  end

  // result queue
  assign out_empty = (ocnt == 2'd0);
  assign out_item  = oq[orptr];
  assign o_pop     = out_pop && !out_empty;

  always_ff @(posedge clk) begin
    if (rd_valid) begin
      oq[owptr].data  <= rd_empty ? 8'd0 : rd_data;
      oq[owptr].last  <= rd_last;
      oq[owptr].empty <= rd_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owptr <= 1'b0;
      orptr <= 1'b0;
      ocnt  <= 2'd0;
    end else begin
      if (rd_valid) owptr <= ~owptr;
      if (o_pop)    orptr <= ~orptr;
      ocnt <= ocnt + {1'b0, rd_valid} - {1'b0, o_pop};
    end
  end

endmodule

`default_nettype wire

[hdl/length_prefixed_frame_receiver_unit.sv]
// Top level of the length-prefixed frame receiver.
// Depends on lpfr_pkg, lpfr_front, lpfr_cmdq, lpfr_back.
//
//   channel   ports                               handshake
//   --------  ----------------------------------  ------------------------
//   rx in     push, full, rx_byte                 push && !full
//   result    empty, pop, out_byte, frame_last,   pop && !empty
//             empty_frame
//   config    cfg_valid, cfg_ready, cfg_data      cfg_valid && cfg_ready
//
// Hunt and length bytes are taken every cycle. A payload byte, or a flag
// that closes a frame, is held off by full while a completed frame is
// queued or still being read out of the payload store: the command is
// popped, then the reads are paced by the two-entry result queue, and
// the hold-off lasts longer while the reader stalls.
// Synchronous reset clears parser phase, counts and queues; start_flag
// resets to 85. The result side stalls on its own behind a two-entry queue.
`default_nettype none

module length_prefixed_frame_receiver_unit #(
  parameter int unsigned STORE_DEPTH = lpfr_pkg::STORE_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  // receive side
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] rx_byte,
  // result side
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_byte,
  output logic            frame_last,
  output logic            empty_frame,
  // start flag register
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_data
);
  import lpfr_pkg::*;

  localparam int unsigned CNT_W  = $clog2(STORE_DEPTH + 1);
  localparam int unsigned ADDR_W = $clog2(STORE_DEPTH);

  logic [7:0]        start_flag;
  logic              store_free;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;
  logic              cmd_push, cmd_pop, cmd_empty, cmd_full;
  logic [CNT_W-1:0]  cmd_in, cmd_out;
  logic              back_busy;
  out_item_t         item;

  // the user must make config writes only while idle; the block does not enforce it, so always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_flag <= FLAG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      start_flag <= cfg_data;
    end
  end

  // store belongs to the front only when nothing is queued or draining
  assign store_free = cmd_empty && !back_busy;

  lpfr_front #(
    .STORE_DEPTH (STORE_DEPTH),
    .CNT_W       (CNT_W),
    .ADDR_W      (ADDR_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .start_flag (start_flag),
    .push       (push),
    .rx_byte    (rx_byte),
    .full       (full),
    .store_free (store_free),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .cmd_push   (cmd_push),
    .cmd_count  (cmd_in)
  );

  lpfr_cmdq #(
    .W (CNT_W)
  ) u_cmdq (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .din   (cmd_in),
    .pop   (cmd_pop),
    .dout  (cmd_out),
    .empty (cmd_empty),
    .full  (cmd_full)
  );

  lpfr_back #(
    .STORE_DEPTH (STORE_DEPTH),
    .CNT_W       (CNT_W),
    .ADDR_W      (ADDR_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .cmd_empty (cmd_empty),
    .cmd_count (cmd_out),
    .cmd_pop   (cmd_pop),
    .busy      (back_busy),
    .out_item  (item),
    .out_empty (empty),
    .out_pop   (pop)
  );

  assign out_byte    = item.data;
  assign frame_last  = item.last;
  assign empty_frame = item.empty;

  // a frame command must never be lost to a full queue
  a_cmd_room: assert property (@(posedge clk) disable iff (rst)
    cmd_push |-> !cmd_full)
    else $error("frame command pushed into full queue");

  // the store is never written while a frame is being read out
  a_store_owner: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (!back_busy && cmd_empty))
    else $error("store written during drain");

  // an empty-frame result is a lone, final, zero item
  a_empty_item: assert property (@(posedge clk) disable iff (rst)
    (!empty && empty_frame) |-> (frame_last && (out_byte == 8'd0)))
    else $error("malformed empty-frame result");

endmodule

`default_nettype wire

[tb/tb_length_prefixed_frame_receiver_unit.sv]
// Self-checking testbench for length_prefixed_frame_receiver_unit: a directed opening, then
// random frame traffic under several start flags, with bursty input and a stalling reader.
// Depends on lpfr_pkg and the receiver RTL.
`default_nettype none

module tb_length_prefixed_frame_receiver_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import lpfr_pkg::*;

  localparam int unsigned HALF_PERIOD   = 4;
  localparam int unsigned RST_CYCLES    = 8;
  localparam int unsigned DEPTH         = STORE_DEPTH_DEF;
  // Longest quiet stretch is the long reader hold; give it plenty of room.
  localparam int unsigned IDLE_LIMIT    = 3000;
  localparam int unsigned HOLD_CYCLES   = 400;
  // Settle time after the owed items are out, scaled with the store depth.
  localparam int unsigned SETTLE        = DEPTH + 40;
  localparam int unsigned NUM_PHASES    = 5;
  localparam int unsigned ITEMS_PER_PHASE = 25;
  localparam int unsigned PRESSURE_PHASE  = 2;

  // Opening items under the reset flag:
  //   hunt noise, a two-byte frame of extreme values, a zero-length frame closed
  //   by a flag, a short frame cut off by a flag, length bytes equal to the flag,
  //   data after a zero length, and a one-byte frame.
  localparam logic [7:0] OPENING [26] = '{
    8'h00, 8'hFF,
    FLAG_RESET, 8'h00, 8'h02, 8'hFF, 8'h00,
    FLAG_RESET, 8'h00, 8'h00, FLAG_RESET,
    8'h00, 8'h03, 8'h11, FLAG_RESET,
    FLAG_RESET, FLAG_RESET, 8'h80, FLAG_RESET,
    8'h00, 8'h00, 8'h7E, FLAG_RESET,
    8'h00, 8'h01, 8'hC3
  };

  typedef enum int {POP_FREE, POP_COIN, POP_THIRDS, POP_SPARSE} pop_style_t;

  // Mirrors the parser and payload store; keeps the frame bytes still owed by the block.
  class deframe_checker;
    logic [7:0]  flag = FLAG_RESET;
    phase_t      ph = PH_HUNT;
    logic [15:0] want_len = '0;
    logic [6:0]  fill = '0;
    logic [7:0]  store [DEPTH];
    out_item_t   due [$];
    int unsigned errors = 0;

    function void queue_frame();
      out_item_t item;
      if (fill == 0) begin
        item = '{data: 8'h00, last: 1'b1, empty: 1'b1};
        due.push_back(item);
      end else begin
        for (int i = 0; i < int'(fill); i++) begin
          item = '{data: store[i], last: (i == int'(fill) - 1), empty: 1'b0};
          due.push_back(item);
        end
      end
    endfunction

    function void take_rx_byte(logic [7:0] b);
      case (ph)
        PH_HUNT: if (b == flag) ph = PH_LEN_HI;
        PH_LEN_HI: begin
          want_len = {8'h00, b};
          ph = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          want_len = {want_len[7:0], b};
          ph = PH_DATA;
        end
        default: begin
          if (b == flag) begin
            if ({9'd0, fill} == want_len) queue_frame();
            fill = '0;
            ph = PH_LEN_HI;
          end else if (fill >= DEPTH) begin
            fill = '0;
            ph = PH_HUNT;
          end else begin
            store[fill] = b;
            fill++;
            if ({9'd0, fill} == want_len) begin
              queue_frame();
              fill = '0;
              ph = PH_HUNT;
            end
          end
        end
      endcase
    endfunction

    function void check_out_item(logic [7:0] got_byte, logic got_last, logic got_empty);
      out_item_t want;
      if (due.size() == 0) begin
        $error("unexpected result: out_byte=%02h frame_last=%0b empty_frame=%0b",
               got_byte, got_last, got_empty);
        errors++;
        return;
      end
      want = due.pop_front();
      if (got_byte !== want.data) begin
        $error("out_byte: expected %02h, actual %02h", want.data, got_byte);
        errors++;
      end
      if (got_last !== want.last) begin
        $error("frame_last: expected %0b, actual %0b", want.last, got_last);
        errors++;
      end
      if (got_empty !== want.empty) begin
        $error("empty_frame: expected %0b, actual %0b", want.empty, got_empty);
        errors++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic [7:0] rx_byte = 8'h00;
  logic       pop = 1'b0;
  logic       cfg_valid = 1'b0;
  logic [7:0] cfg_data = 8'h00;
  wire logic       full;
  wire logic       empty;
  wire logic [7:0] out_byte;
  wire logic       frame_last;
  wire logic       empty_frame;
  wire logic       cfg_ready;

  deframe_checker model = new;

  int unsigned burst_left = 0;    // items left in the current sender burst
  int unsigned phase_items = 0;   // items accepted in the current random phase
  bit          hold_request = 1'b0;

  length_prefixed_frame_receiver_unit #(
    .STORE_DEPTH(DEPTH)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .rx_byte    (rx_byte),
    .empty      (empty),
    .pop        (pop),
    .out_byte   (out_byte),
    .frame_last (frame_last),
    .empty_frame(empty_frame),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // Watchdog: any handshake on any channel counts as progress.
  int unsigned quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == IDLE_LIMIT) begin
      $display("tb_length_prefixed_frame_receiver_unit: done, errors");
      $finish;
    end
  end

  // Result side: compare every item taken off the block.
  always @(posedge clk) begin
    if (!rst && pop && !empty) model.check_out_item(out_byte, frame_last, empty_frame);
  end

  // Reader stalls: a style is picked for a random stretch, free-running included.
  // A hold request from the stimulus turns into one long stretch with pop low, so the
  // result queue and store back up and full reaches the sender.
  pop_style_t  pop_style = POP_FREE;
  int unsigned style_left = 0;
  int unsigned hold_left = 0;
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_left != 0) begin
      pop <= 1'b0;
      hold_left = hold_left - 1;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left = HOLD_CYCLES;
      pop <= 1'b0;
    end else begin
      if (style_left == 0) begin
        pop_style = pop_style_t'($urandom_range(0, 3));
        style_left = $urandom_range(8, 64);
      end
      style_left = style_left - 1;
      case (pop_style)
        POP_FREE:   pop <= 1'b1;
        POP_COIN:   pop <= 1'($urandom_range(0, 1));
        POP_THIRDS: pop <= (style_left % 3) != 0;
        default:    pop <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Offers one item and waits until it is taken. Called and returns at a falling edge.
  // The sender works in bursts; a gap drops push before the next burst.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        push <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    push <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (full) @(posedge clk);
    model.take_rx_byte(b);
    phase_items++;
    @(negedge clk);
  endtask

  function automatic logic [7:0] any_but_flag();
    logic [7:0] v;
    do v = 8'($urandom_range(0, 255)); while (v == model.flag);
    return v;
  endfunction

  task automatic send_header(input logic [15:0] len);
    send_byte(model.flag);
    send_byte(len[15:8]);
    send_byte(len[7:0]);
  endtask

  // Length past the store: DEPTH bytes fill it, the next one drops the frame.
  task automatic send_oversize();
    send_header(16'($urandom_range(DEPTH + 1, 65535)));
    repeat (DEPTH + 1) send_byte(any_but_flag());
  endtask

  // Mostly well-formed frames with random content; the rest are zero-length frames,
  // frames cut short by the next flag, stray data after a zero length, oversize
  // frames and plain noise.
  task automatic send_frame();
    int unsigned kind;
    int unsigned len;
    kind = $urandom_range(0, 99);
    if (kind < 65) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, DEPTH) : $urandom_range(1, 8);
      send_header(16'(len));
      repeat (len) send_byte(any_but_flag());
    end else if (kind < 75) begin
      send_header(16'd0);
    end else if (kind < 85) begin
      len = $urandom_range(1, 12);
      send_header(16'(len));
      repeat ($urandom_range(0, len - 1)) send_byte(any_but_flag());
    end else if (kind < 90) begin
      send_header(16'd0);
      repeat ($urandom_range(1, 3)) send_byte(any_but_flag());
    end else if (kind < 93) begin
      send_oversize();
    end else begin
      repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // Block is idle once every owed item has come out and the drain has had time to finish.
  task automatic wait_drained();
    while (model.due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_flag(input logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    model.flag = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [7:0] next_flag;
    repeat (RST_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (OPENING[i]) send_byte(OPENING[i]);
    push <= 1'b0;
    wait_drained();

    // Random phases, each under its own start flag: both extremes, the reset value
    // and random ones. The first phase opens with a full-size frame and an oversize one.
    for (int unsigned p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       next_flag = 8'h00;
        1:       next_flag = 8'hFF;
        3:       next_flag = FLAG_RESET;
        default: next_flag = 8'($urandom_range(0, 255));
      endcase
      write_flag(next_flag);
      phase_items = 0;
      if (p == PRESSURE_PHASE) hold_request = 1'b1;
      if (p == 0) begin
        send_header(16'(DEPTH));
        repeat (DEPTH) send_byte(any_but_flag());
        send_oversize();
        phase_items = 0;
      end
      while (phase_items < ITEMS_PER_PHASE) send_frame();
      push <= 1'b0;
      wait_drained();
    end

    if (model.errors == 0 && model.due.size() == 0) begin
      $display("tb_length_prefixed_frame_receiver_unit: done, clean");
    end else begin
      $display("tb_length_prefixed_frame_receiver_unit: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
